[rtl/core/vrm_pkg.sv]
// Package for the voice resample mixer: payload structs, command and
// register codes, and fixed widths. No dependencies.
package vrm_pkg;

  localparam int AddrBits     = 14;   // store depth is 2**AddrBits
  localparam int FracBits     = 16;
  localparam int AttackFrames = 16;
  localparam int AttackShift  = 4;
  localparam int FilterBits   = 16;
  localparam int Vol16Shift   = 8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_MIX   = 2'd2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_VOL_LEFT  = 3'd1;
  localparam logic [2:0] REG_VOL_RIGHT = 3'd2;
  localparam logic [2:0] REG_STEP      = 3'd3;
  localparam logic [2:0] REG_COEF_IN   = 3'd4;
  localparam logic [2:0] REG_COEF_FB1  = 3'd5;
  localparam logic [2:0] REG_COEF_FB2  = 3'd6;

  typedef struct packed {
    logic [1:0]          command;
    logic [13:0]         address;
    logic signed [15:0]  sample_value;
    logic [15:0]         start_fraction;
    logic [4:0]          attack_count;
    logic signed [31:0]  acc_first_in;
    logic signed [31:0]  acc_second_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]  acc_first_out;
    logic signed [31:0]  acc_second_out;
    logic [13:0]         position_out;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;

endpackage

[rtl/core/vrm_chan_if.sv]
// Valid/ready channel carrying one payload word of type T.
// Used with the structs of vrm_pkg.
interface vrm_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/voice_resample_mixer_top.sv]
// Voice resample mixer top level: sample store, resampler, filter, ramp.
// Depends on vrm_pkg and vrm_chan_if.
//
// Load and start words are taken without leaving the idle state. A mix word
// holds the input until its result enters the output register and the
// sequencer returns to idle. Its steps, in order: two reads of the sample
// store (current and next sample), interpolation, volume multiply, filter
// products, filter sum, attack ramp and the final add.
// While an earlier result still waits in the output register the mix holds
// in its last step until that result is taken. One word is worked on at a
// time; load and start words are taken while a finished result still waits
// in the output register. Configuration writes are taken in any cycle. The
// store has no reset; reading an unwritten entry returns undefined data.
module voice_resample_mixer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  vrm_chan_if.sink   in_i,
  vrm_chan_if.sink   cfg_i,
  vrm_chan_if.source out_o
);
  import vrm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_INTP = 3'd2;
  localparam logic [2:0] S_VOL  = 3'd3;
  localparam logic [2:0] S_FMUL = 3'd4;
  localparam logic [2:0] S_FSUM = 3'd5;
  localparam logic [2:0] S_RAMP = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;

  // configuration
  logic [3:0]         mode_q;
  logic [15:0]        vol_l_q, vol_r_q;
  logic [19:0]        step_q;
  logic signed [31:0] coef_in_q, coef_fb1_q, coef_fb2_q;

  // voice state
  logic [AddrBits-1:0] pos_q;
  logic [FracBits-1:0] frac_q;
  logic [4:0]          atk_q;
  logic signed [31:0]  h1_0_q, h1_1_q, h2_0_q, h2_1_q;

  // datapath
  logic signed [15:0] mem [2**AddrBits];
  logic signed [15:0] rdata_q, s0_q;
  logic signed [16:0] smp_q;
  logic signed [33:0] pv1_q, pv2_q;
  logic signed [63:0] m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
  logic signed [31:0] c1_q, c2_q, r1_q, r2_q;
  logic signed [31:0] acc1_q, acc2_q;
  logic               out_valid_q;
  out_word_t          out_q;

  logic stereo, itp, filt_on, ramp_on, in_fire, out_free;
  assign stereo  = mode_q[0];
  assign itp     = mode_q[1];
  assign filt_on = mode_q[1] & mode_q[2];
  assign ramp_on = itp && (atk_q != '0);

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // sample store: write on load, read current then next position
  logic [AddrBits-1:0] raddr;
  assign raddr = (state_q == S_IDLE) ? pos_q : pos_q + AddrBits'(1);

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.data.command == CMD_LOAD) begin
      mem[in_i.data.address[AddrBits-1:0]] <= in_i.data.sample_value;
    end
    rdata_q <= mem[raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && in_i.data.command == CMD_MIX) state_d = S_RD1;
      S_RD1:  state_d = S_INTP;
      S_INTP: state_d = S_VOL;
      S_VOL:  state_d = S_FMUL;
      S_FMUL: state_d = S_FSUM;
      S_FSUM: state_d = S_RAMP;
      S_RAMP: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // interpolation, volume, filter products and ramp terms
  logic signed [16:0] diff;
  logic signed [33:0] ipro;
  logic [15:0]        vl, vr;
  logic signed [65:0] p10, p20;
  logic signed [63:0] sum1, sum2;
  logic signed [31:0] c1_n, c2_n;
  logic [4:0]         atk_gain;
  logic signed [37:0] rp1, rp2;
  logic signed [31:0] rw1, rw2;
  logic [FracBits:0]  fsum;

  always_comb begin
    diff     = {rdata_q[15], rdata_q} - {s0_q[15], s0_q};
    ipro     = $signed({1'b0, frac_q}) * diff;
    vl       = mode_q[3] ? (vol_l_q >> Vol16Shift) : vol_l_q;
    vr       = mode_q[3] ? (vol_r_q >> Vol16Shift) : vol_r_q;
    p10      = coef_in_q * pv1_q;
    p20      = coef_in_q * pv2_q;
    sum1     = m10_q + m11_q + m12_q;
    sum2     = m20_q + m21_q + m22_q;
    c2_n     = filt_on ? sum2[FilterBits+31:FilterBits] : pv2_q[31:0];
    c1_n     = !stereo ? c2_n
             : (filt_on ? sum1[FilterBits+31:FilterBits] : pv1_q[31:0]);
    atk_gain = 5'(AttackFrames) - atk_q;
    rp1      = c1_q * $signed({1'b0, atk_gain});
    rp2      = c2_q * $signed({1'b0, atk_gain});
    rw1      = rp1[31:0];
    rw2      = rp2[31:0];
    fsum     = {1'b0, frac_q} + (FracBits+1)'(step_q[FracBits-1:0]);
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc1_q <= in_i.data.acc_first_in;
      acc2_q <= in_i.data.acc_second_in;
    end
    if (state_q == S_RD1) s0_q <= rdata_q;
    if (state_q == S_INTP) begin
      smp_q <= itp ? 17'({s0_q[15], s0_q} + ipro[FracBits+16:FracBits])
                   : {s0_q[15], s0_q};
    end
    if (state_q == S_VOL) begin
      pv1_q <= smp_q * $signed({1'b0, vr});
      pv2_q <= smp_q * $signed({1'b0, vl});
    end
    if (state_q == S_FMUL) begin
      m10_q <= p10[63:0];
      m11_q <= 64'(coef_fb1_q * h1_0_q);
      m12_q <= 64'(coef_fb2_q * h1_1_q);
      m20_q <= p20[63:0];
      m21_q <= 64'(coef_fb1_q * h2_0_q);
      m22_q <= 64'(coef_fb2_q * h2_1_q);
    end
    if (state_q == S_FSUM) begin
      c1_q <= c1_n;
      c2_q <= c2_n;
    end
    if (state_q == S_RAMP) begin
      r1_q <= ramp_on ? (rw1 >>> AttackShift) : c1_q;
      r2_q <= ramp_on ? (rw2 >>> AttackShift) : c2_q;
    end
  end

  // control, configuration, voice state and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= '0;
      vol_l_q     <= '0;
      vol_r_q     <= '0;
      step_q      <= 20'h10000;
      coef_in_q   <= '0;
      coef_fb1_q  <= '0;
      coef_fb2_q  <= '0;
      pos_q       <= '0;
      frac_q      <= '0;
      atk_q       <= '0;
      h1_0_q      <= '0;
      h1_1_q      <= '0;
      h2_0_q      <= '0;
      h2_1_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      // take register writes
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_MODE:      mode_q     <= cfg_i.data.data[3:0];
          REG_VOL_LEFT:  vol_l_q    <= cfg_i.data.data[15:0];
          REG_VOL_RIGHT: vol_r_q    <= cfg_i.data.data[15:0];
          REG_STEP:      step_q     <= cfg_i.data.data[19:0];
          REG_COEF_IN:   coef_in_q  <= cfg_i.data.data;
          REG_COEF_FB1:  coef_fb1_q <= cfg_i.data.data;
          REG_COEF_FB2:  coef_fb2_q <= cfg_i.data.data;
          default: ;
        endcase
      end

      // start: set position, fraction and attack, clear history
      if (in_fire && in_i.data.command == CMD_START) begin
        pos_q  <= in_i.data.address[AddrBits-1:0];
        frac_q <= in_i.data.start_fraction[FracBits-1:0];
        atk_q  <= (in_i.data.attack_count > 5'(AttackFrames))
                  ? 5'(AttackFrames) : in_i.data.attack_count;
        h1_0_q <= '0;
        h1_1_q <= '0;
        h2_0_q <= '0;
        h2_1_q <= '0;
      end

      // shift filter history
      if (state_q == S_FSUM && filt_on) begin
        h2_1_q <= h2_0_q;
        h2_0_q <= c2_n;
        if (stereo) begin
          h1_1_q <= h1_0_q;
          h1_0_q <= c1_n;
        end
      end

      // drop the word once taken, unless a new one replaces it
      if (out_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;

      // finish mix: add accumulators, advance position, count down attack
      if (state_q == S_DONE && out_free) begin
        out_valid_q          <= 1'b1;
        out_q.acc_first_out  <= acc1_q + r1_q;
        out_q.acc_second_out <= stereo ? acc2_q + r2_q : acc2_q;
        out_q.position_out   <= pos_q + AddrBits'(step_q[19:FracBits]) +
                                AddrBits'(fsum[FracBits]);
        pos_q                <= pos_q + AddrBits'(step_q[19:FracBits]) +
                                AddrBits'(fsum[FracBits]);
        frac_q               <= fsum[FracBits-1:0];
        if (ramp_on) atk_q <= atk_q - 5'd1;
      end
    end
  end

  // checks
  a_atk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    atk_q <= 5'(AttackFrames)) else $error("attack count out of range");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without mix");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |=> (state_q == S_INTP)) else $error("sequencer slipped");

endmodule

[tb/voice_resample_mixer_top_tb.sv]
// Testbench for voice_resample_mixer_top: random and directed load, start and
// mix words, checked against a predictor of the voice. Needs vrm_pkg, vrm_chan_if.
module voice_resample_mixer_top_tb;
  import vrm_pkg::*;

  localparam int StoreDepth = 1 << AddrBits;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk_i;
  logic rst_ni;

  vrm_chan_if #(.T(in_word_t))  in_if ();
  vrm_chan_if #(.T(cfg_word_t)) cfg_if ();
  vrm_chan_if #(.T(out_word_t)) out_if ();

  voice_resample_mixer_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // predictor state of the voice
  logic signed [15:0] sample_mem [StoreDepth];
  bit                 sample_loaded [StoreDepth];
  logic [AddrBits-1:0] play_pos;
  logic [FracBits-1:0] play_frac;
  logic [4:0]          attack_left;
  int                  filt_hist [2][2];   // [0] second slot, [1] first slot
  logic [3:0]          cfg_mode;
  logic [15:0]         cfg_vol_left, cfg_vol_right;
  logic [19:0]         cfg_step;
  int                  cfg_coef_in, cfg_coef_fb1, cfg_coef_fb2;

  in_word_t  word_queue [$];
  out_word_t mix_results [$];
  int        n_queued, n_taken, n_mixes, n_loads, n_starts, n_checked, n_errors;
  int        cycle_count;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    fork
      forever #4 clk_i = ~clk_i;
      begin
        repeat (2) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  function automatic int filter_tap(longint smp, longint vol, int slot);
    longint acc;
    int     y;
    acc = longint'(cfg_coef_in) * smp * vol
        + longint'(cfg_coef_fb1) * longint'(filt_hist[slot][0])
        + longint'(cfg_coef_fb2) * longint'(filt_hist[slot][1]);
    y = int'(acc >>> FilterBits);
    filt_hist[slot][1] = filt_hist[slot][0];
    filt_hist[slot][0] = y;
    return y;
  endfunction

  function automatic int attack_scale(int v);
    int tmp;
    tmp = int'(longint'(v) * longint'(AttackFrames - int'(attack_left)));
    return tmp >>> AttackShift;
  endfunction

  // compute one mixed frame and advance the play position
  function automatic out_word_t mix_frame(in_word_t w);
    out_word_t r;
    longint    vl, vr, smp, nxt, f;
    int        c1, c2;
    bit        stereo, interp, ramp_on;
    stereo = cfg_mode[0];
    interp = cfg_mode[1];
    vl = longint'(cfg_vol_left);
    vr = longint'(cfg_vol_right);
    if (cfg_mode[3]) begin
      vl = vl >> Vol16Shift;
      vr = vr >> Vol16Shift;
    end
    smp = longint'(sample_mem[play_pos]);
    if (interp) begin
      nxt = longint'(sample_mem[play_pos + 1'b1]);
      smp = smp + ((longint'(play_frac) * (nxt - smp)) >>> FracBits);
    end
    if (interp && cfg_mode[2]) begin
      c2 = filter_tap(smp, vl, 0);
      c1 = stereo ? filter_tap(smp, vr, 1) : c2;
    end else begin
      c2 = int'(smp * vl);
      c1 = stereo ? int'(smp * vr) : c2;
    end
    ramp_on = interp && (attack_left != 0);
    if (ramp_on) begin
      c1 = attack_scale(c1);
      c2 = attack_scale(c2);
      attack_left = attack_left - 1'b1;
    end
    r.acc_first_out = w.acc_first_in + c1;
    r.acc_second_out = stereo ? w.acc_second_in + c2 : w.acc_second_in;
    f = longint'(play_frac) + longint'(cfg_step);
    play_pos = play_pos + AddrBits'(f >> FracBits);
    play_frac = f[FracBits-1:0];
    r.position_out = play_pos;
    return r;
  endfunction

  // update predictor and queue the word for the driver
  task automatic send_word(in_word_t w);
    case (w.command)
      CMD_LOAD: begin
        sample_mem[w.address] = w.sample_value;
        sample_loaded[w.address] = 1'b1;
        n_loads++;
      end
      CMD_START: begin
        play_pos = w.address;
        play_frac = w.start_fraction;
        attack_left = (w.attack_count > AttackFrames) ? 5'(AttackFrames) : w.attack_count;
        filt_hist = '{'{0, 0}, '{0, 0}};
        n_starts++;
      end
      CMD_MIX: begin
        mix_results.push_back(mix_frame(w));
        n_mixes++;
      end
      default: ;
    endcase
    word_queue.push_back(w);
    n_queued++;
  endtask

  function automatic in_word_t random_word(logic [1:0] cmd);
    in_word_t w;
    w.command = cmd;
    w.address = AddrBits'($urandom_range(0, StoreDepth - 1));
    w.sample_value = 16'($urandom);
    w.start_fraction = 16'($urandom);
    w.attack_count = 5'($urandom_range(0, 31));
    w.acc_first_in = $urandom;
    w.acc_second_in = $urandom;
    return w;
  endfunction

  task automatic send_load(int addr, int value);
    in_word_t w;
    w = random_word(CMD_LOAD);
    w.address = AddrBits'(addr);
    w.sample_value = 16'(value);
    send_word(w);
  endtask

  task automatic send_start(int addr, int frac, int attack);
    in_word_t w;
    w = random_word(CMD_START);
    w.address = AddrBits'(addr);
    w.start_fraction = 16'(frac);
    w.attack_count = 5'(attack);
    send_word(w);
  endtask

  // load any sample the next frame reads but was never written
  task automatic send_mix(int acc1, int acc2);
    in_word_t w;
    logic [AddrBits-1:0] nxt;
    nxt = play_pos + 1'b1;
    if (!sample_loaded[play_pos]) send_load(play_pos, $urandom);
    if (cfg_mode[1] && !sample_loaded[nxt]) send_load(nxt, $urandom);
    w = random_word(CMD_MIX);
    w.acc_first_in = acc1;
    w.acc_second_in = acc2;
    send_word(w);
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || mix_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: value};
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic set_config(logic [3:0] m, logic [15:0] vl, logic [15:0] vr,
                            logic [19:0] st, int ci, int f1, int f2);
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_VOL_LEFT, 32'(vl));
    write_reg(REG_VOL_RIGHT, 32'(vr));
    write_reg(REG_STEP, 32'(st));
    write_reg(REG_COEF_IN, ci);
    write_reg(REG_COEF_FB1, f1);
    write_reg(REG_COEF_FB2, f2);
    cfg_if.valid <= 1'b0;
    cfg_mode = m;
    cfg_vol_left = vl;
    cfg_vol_right = vr;
    cfg_step = st;
    cfg_coef_in = ci;
    cfg_coef_fb1 = f1;
    cfg_coef_fb2 = f2;
  endtask

  // queue n_items words, counting the loads that mixes pull in
  task automatic random_phase(int n_items);
    int first;
    int pick;
    first = n_queued;
    while (n_queued - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_start($urandom_range(0, StoreDepth - 1), $urandom, $urandom_range(0, 31));
      end else if (pick < 15) begin
        send_word(random_word(CMD_LOAD));
      end else if (pick < 18) begin
        send_word(random_word(CMD_NONE));
      end else begin
        send_mix($urandom, $urandom);
      end
    end
  endtask

  // stimulus: directed words, then random phases over several settings
  initial begin
    play_pos = '0;
    play_frac = '0;
    attack_left = '0;
    filt_hist = '{'{0, 0}, '{0, 0}};
    cfg_mode = '0;
    cfg_vol_left = '0;
    cfg_vol_right = '0;
    cfg_step = 20'd65536;
    cfg_coef_in = 0;
    cfg_coef_fb1 = 0;
    cfg_coef_fb2 = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // stereo, interpolate and filter on the store edges
    set_config(4'b0111, 16'hffff, 16'hffff, 20'h18000, 32'h0001_0000, 32'h0000_8000,
               -32'sd16384);
    send_load(0, 32767);
    send_load(1, -32768);
    send_load(16383, -32768);
    send_load(16382, 32767);
    send_load(100, 16'h1234);
    send_start(16382, 65535, 17);
    send_mix(32'h7fff_ffff, 32'h8000_0000);
    send_mix(32'h8000_0000, 32'h7fff_ffff);
    send_mix(0, -1);
    send_mix(-1, 0);
    send_start(0, 0, 0);
    send_mix(32'h7fff_ffff, 32'h7fff_ffff);
    send_mix(32'h8000_0000, 32'h8000_0000);
    send_start(0, 32768, 31);
    send_mix(0, 0);
    send_word(random_word(CMD_NONE));
    send_start(16383, 0, 16);
    send_mix(1, 1);
    send_mix(-1, -1);
    wait_idle();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: set_config(4'b0000, 16'h1234, 16'h4321, 20'd65536, 0, 0, 0);
        1: set_config(4'b1111, 16'hffff, 16'hffff, 20'hfffff, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff);
        2: set_config(4'b0100, 16'h0000, 16'h0000, 20'h00000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000);
        3: set_config(4'b1000, 16'hffff, 16'h0001, 20'h08000, 32'h0000_4000, 0, 0);
        default: set_config(4'($urandom), 16'($urandom), 16'($urandom),
                            20'($urandom_range(0, 20'h3ffff)), $urandom,
                            $signed($urandom) >>> 14, $signed($urandom) >>> 14);
      endcase
      random_phase(75);
      wait_idle();
    end

    $display("tb: %0d frames checked over 12 settings; %0d loads, %0d starts sent",
             n_checked, n_loads, n_starts);
    $display("tb: %0d mismatches, %0d cycles", n_errors, cycle_count);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // drive words in bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          in_if.data <= word_queue.pop_front();
          in_if.valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // stall the result side on a shifting pattern, with one long hold
  int stall_style, style_left, hold_left, mix_taken;
  bit long_hold_done;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready && in_if.data.command == CMD_MIX) mix_taken++;
      if (!long_hold_done && mix_taken >= 150) begin
        hold_left = 600;
        long_hold_done = 1'b1;
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(16, 128);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_style)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= $urandom_range(0, 1);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // check each result word against the oldest predicted frame
  out_word_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (in_if.valid && in_if.ready) n_taken++;
      if (out_if.valid && out_if.ready) begin
        if (mix_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("tb: unexpected result word %h", out_if.data);
        end else begin
          want = mix_results.pop_front();
          n_checked++;
          if (out_if.data.acc_first_out !== want.acc_first_out ||
              out_if.data.acc_second_out !== want.acc_second_out ||
              out_if.data.position_out !== want.position_out) begin
            n_errors++;
            if (n_errors <= 10)
              $display("tb: frame %0d: want %h %h %0d, got %h %h %0d", n_checked,
                       want.acc_first_out, want.acc_second_out, want.position_out,
                       out_if.data.acc_first_out, out_if.data.acc_second_out,
                       out_if.data.position_out);
          end
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("tb: timeout with %0d frames outstanding", mix_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
